// ===== hdl/ffbp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants of the fixed frame byte parser.
// ---------------------------------------------------------------------------
package ffbp_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int POS_W       = 4;
    localparam int FIFO_DEPTH  = 2;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE   = 4'd1;
    localparam logic [POS_W-1:0] POS_LENGTH = 4'd2;
    localparam logic [POS_W-1:0] POS_X_HI   = 4'd3;
    localparam logic [POS_W-1:0] POS_X_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_HI   = 4'd5;
    localparam logic [POS_W-1:0] POS_Y_LO   = 4'd6;
    localparam logic [POS_W-1:0] POS_Z_HI   = 4'd7;
    localparam logic [POS_W-1:0] POS_Z_LO   = 4'd8;
    localparam logic [POS_W-1:0] POS_FLAGS  = 4'd9;
    localparam logic [POS_W-1:0] POS_CHECK  = 4'd10;
    localparam logic [POS_W-1:0] POS_TAIL   = 4'd11;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 2'd3;

    localparam logic [7:0] HEADER_RESET   = 8'd170;
    localparam logic [7:0] TAIL_RESET     = 8'd85;
    localparam logic [7:0] LENGTH_RESET   = 8'd12;
    localparam logic [7:0] VELOCITY_RESET = 8'd1;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_TAIL  = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
    localparam logic [1:0] STATUS_BAD_CHECK = 2'd3;

    localparam int OUT_DATA_W = 120;

    // checked frame as handed from the front to the back
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  frame_type;
        logic        is_velocity;
        logic [7:0]  sign_flags;
        logic [15:0] x_word;
        logic [15:0] y_word;
        logic [15:0] z_word;
    } ffbp_frame_t;

endpackage
`default_nettype wire

// ===== hdl/fixed_frame_byte_parser_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fixed_frame_byte_parser_unit
// Fixed 12-byte frame parser with 8-bit sum check, one byte per item.
// ---------------------------------------------------------------------------
// The unit takes one received byte every clock cycle while s_tready is high.
// While hunting it drops bytes until one matches the header register, then
// collects the next eleven bytes with no resync inside the frame. On the
// twelfth byte the front checks tail, length and the running sum and queues
// one result; the back turns the three big-endian int16 values into
// magnitude and signed form. Results pass through the queue into the output
// register. The running sum and byte counter take a byte per cycle; s_tready
// drops only when the two-entry queue is full under output backpressure.
module fixed_frame_byte_parser_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [9:2] frame_type, [10] is_velocity, [18:11] sign_flags,
    // [34:19] x_magnitude, [50:35] y_magnitude, [66:51] z_magnitude,
    // [83:67] x_signed, [100:84] y_signed, [117:101] z_signed, [119:118] zero
    output logic [ffbp_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [ffbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                      cfg_wdata
);
    import ffbp_pkg::*;

    logic        push, pop, full, empty;
    ffbp_frame_t push_frame, pop_frame;

    ffbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fifo_full  (full),
        .push       (push),
        .push_frame (push_frame)
    );

    ffbp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .full       (full),
        .empty      (empty)
    );

    ffbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop_frame (pop_frame),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/ffbp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ffbp_front
// Header hunt, byte collection, running sum and frame checks.
// ---------------------------------------------------------------------------
module ffbp_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [ffbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                      cfg_wdata,
    input  wire logic                            fifo_full,
    output logic                                 push,
    output ffbp_pkg::ffbp_frame_t                push_frame
);
    import ffbp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       frame_reg [1:10];
    logic [7:0]       header_reg, tail_reg, length_reg, velocity_reg;
    logic             accept;
    logic [1:0]       status;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (pos_reg == POS_TAIL);

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (accept) begin
            if (pos_reg == POS_HEADER) begin
                if (s_tdata == header_reg) begin
                    pos_next = POS_TYPE;
                    sum_next = 8'd0;
                end
            end else if (pos_reg == POS_TAIL) begin
                pos_next = POS_HEADER;
            end else begin
                pos_next = pos_reg + 4'd1;
                if (pos_reg <= POS_FLAGS) begin
                    sum_next = sum_reg + s_tdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_HEADER;
            header_reg   <= HEADER_RESET;
            tail_reg     <= TAIL_RESET;
            length_reg   <= LENGTH_RESET;
            velocity_reg <= VELOCITY_RESET;
        end else begin
            pos_reg <= pos_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HEADER:   header_reg   <= cfg_wdata;
                    CFG_TAIL:     tail_reg     <= cfg_wdata;
                    CFG_LENGTH:   length_reg   <= cfg_wdata;
                    CFG_VELOCITY: velocity_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload: byte store and running sum
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (accept && pos_reg >= POS_TYPE && pos_reg <= POS_CHECK) begin
            frame_reg[pos_reg] <= s_tdata;
        end
    end

    // checks in priority order, tail byte is the one arriving now
    always_comb begin
        if (s_tdata != tail_reg) begin
            status = STATUS_BAD_TAIL;
        end else if (frame_reg[POS_LENGTH] != length_reg) begin
            status = STATUS_BAD_LEN;
        end else if (sum_reg != frame_reg[POS_CHECK]) begin
            status = STATUS_BAD_CHECK;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        push_frame.status      = status;
        push_frame.frame_type  = frame_reg[POS_TYPE];
        push_frame.is_velocity = (status == STATUS_OK) && (frame_reg[POS_TYPE] == velocity_reg);
        push_frame.sign_flags  = frame_reg[POS_FLAGS];
        push_frame.x_word      = {frame_reg[POS_X_HI], frame_reg[POS_X_LO]};
        push_frame.y_word      = {frame_reg[POS_Y_HI], frame_reg[POS_Y_LO]};
        push_frame.z_word      = {frame_reg[POS_Z_HI], frame_reg[POS_Z_LO]};
    end

endmodule
`default_nettype wire

// ===== hdl/ffbp_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ffbp_fifo
// Short queue of checked frames between the front and the back.
// ---------------------------------------------------------------------------
module ffbp_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire ffbp_pkg::ffbp_frame_t push_frame,
    input  wire logic                  pop,
    output ffbp_pkg::ffbp_frame_t      pop_frame,
    output logic                       full,
    output logic                       empty
);
    import ffbp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    ffbp_frame_t      mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_frame = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ffbp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ffbp_back
// Magnitude and sign of the three values, result output register.
// ---------------------------------------------------------------------------
module ffbp_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                empty,
    input  wire ffbp_pkg::ffbp_frame_t               pop_frame,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ffbp_pkg::OUT_DATA_W-1:0]          m_tdata
);
    import ffbp_pkg::*;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] tdata_next;
    logic [15:0]           x_mag, y_mag, z_mag;
    logic [16:0]           x_sgn, y_sgn, z_sgn;
    logic                  ok;

    assign pop      = !empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // 0x8000 maps to magnitude 0x8000
    function automatic logic [15:0] magnitude(input logic [15:0] w);
        return w[15] ? (~w + 16'd1) : w;
    endfunction

    function automatic logic [16:0] signed_value(input logic [15:0] mag, input logic positive);
        logic [16:0] m17;
        m17 = {1'b0, mag};
        return positive ? m17 : (~m17 + 17'd1);
    endfunction

    always_comb begin
        ok    = (pop_frame.status == STATUS_OK);
        x_mag = ok ? magnitude(pop_frame.x_word) : 16'd0;
        y_mag = ok ? magnitude(pop_frame.y_word) : 16'd0;
        z_mag = ok ? magnitude(pop_frame.z_word) : 16'd0;
        x_sgn = signed_value(x_mag, pop_frame.sign_flags[0]);
        y_sgn = signed_value(y_mag, pop_frame.sign_flags[1]);
        z_sgn = signed_value(z_mag, pop_frame.sign_flags[2]);
        tdata_next = {2'b00, z_sgn, y_sgn, x_sgn, z_mag, y_mag, x_mag,
                      pop_frame.sign_flags, pop_frame.is_velocity,
                      pop_frame.frame_type, pop_frame.status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= tdata_next;
        end
    end

endmodule
`default_nettype wire
